// File: hw/rtl/qpc_pkg.sv
// shared types and constants for the queen path counter
`timescale 1ns / 1ps
`default_nettype none

package qpc_pkg;

   localparam int MOD_W  = 30;
   localparam int ROWS_W = 16;
   localparam int COLS_W = 11;

   localparam logic [MOD_W-1:0] MODULUS_RESET = 30'd1000000007;

   // register index as seen on address bit 2 (byte address 4*i)
   localparam logic REG_MODULUS = 1'b0;

   typedef struct packed {
      logic              start;
      logic [ROWS_W-1:0] rows;
      logic [COLS_W-1:0] cols;
   } sweep_cmd_type;

   typedef struct packed {
      logic idle;
      logic done;
   } sweep_status_type;

endpackage

`default_nettype wire

// File: hw/rtl/qpc_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module qpc_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/qpc_addmod.sv
// shared modular adder, operands below the modulus
`timescale 1ns / 1ps
`default_nettype none

module qpc_addmod #(
   parameter int WIDTH = 30
) (
   input  wire logic [WIDTH-1:0] op_a,
   input  wire logic [WIDTH-1:0] op_b,
   input  wire logic [WIDTH-1:0] modulus,
   output logic [WIDTH-1:0]      sum
);

   logic [WIDTH:0] raw;

   always_comb begin
      raw = {1'b0, op_a} + {1'b0, op_b};
      if (raw >= {1'b0, modulus}) begin
         raw = raw - {1'b0, modulus};
      end
      sum = raw[WIDTH-1:0];
   end

endmodule

`default_nettype wire

// File: hw/rtl/qpc_sweep.sv
// grid sweep sequencer with column and diagonal stores
`timescale 1ns / 1ps
`default_nettype none

module qpc_sweep #(
   parameter int MAX_COLS  = 1024,
   parameter int SUM_WIDTH = 30
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire qpc_pkg::sweep_cmd_type      cmd,
   input  wire logic [SUM_WIDTH-1:0]        modulus,
   input  wire logic                        ack,
   output qpc_pkg::sweep_status_type        status,
   output logic [SUM_WIDTH-1:0]             result
);

   localparam int CW = $clog2(MAX_COLS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD_COL,
      ST_ADD_DIAG,
      ST_WR_COL,
      ST_WR_DIAG,
      ST_ROW_ADD,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [qpc_pkg::ROWS_W-1:0]   row_ff, row_in;
   logic [qpc_pkg::ROWS_W-1:0]   last_row_ff, last_row_in;
   logic [CW-1:0]                col_ff, col_in;
   logic [CW-1:0]                last_col_ff, last_col_in;
   logic [SUM_WIDTH-1:0]         acc_ff, acc_in;
   logic [SUM_WIDTH-1:0]         cell_ff, cell_in;
   logic [SUM_WIDTH-1:0]         row_prefix_ff, row_prefix_in;
   logic [SUM_WIDTH-1:0]         diag_carry_ff, diag_carry_in;

   logic [SUM_WIDTH-1:0]         op_a, op_b, sum;
   logic [SUM_WIDTH-1:0]         col_rd, diag_rd;
   logic [SUM_WIDTH-1:0]         col_term, diag_term;
   logic                         col_wr, diag_wr, rd_en;
   logic [CW-1:0]                rd_addr;
   logic                         first_row, first_col;

   qpc_ram #(.WIDTH(SUM_WIDTH), .DEPTH(MAX_COLS)) u_col_ram (
      .clock   (clock),
      .wr_en   (col_wr),
      .wr_addr (col_ff),
      .wr_data (sum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (col_rd)
   );

   qpc_ram #(.WIDTH(SUM_WIDTH), .DEPTH(MAX_COLS)) u_diag_ram (
      .clock   (clock),
      .wr_en   (diag_wr),
      .wr_addr (col_ff),
      .wr_data (sum),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (diag_rd)
   );

   qpc_addmod #(.WIDTH(SUM_WIDTH)) u_addmod (
      .op_a    (op_a),
      .op_b    (op_b),
      .modulus (modulus),
      .sum     (sum)
   );

   assign first_row = (row_ff == '0);
   assign first_col = (col_ff == '0);
   assign col_term  = first_row ? '0 : col_rd;
   assign diag_term = (first_row || first_col) ? '0 : diag_carry_ff;

   // operand selection for the one adder
   always_comb begin
      case (state_ff)
         ST_ADD_COL: begin
            op_a = row_prefix_ff;
            op_b = col_term;
         end
         ST_ADD_DIAG: begin
            op_a = acc_ff;
            op_b = diag_term;
         end
         ST_WR_COL: begin
            op_a = cell_ff;
            op_b = col_term;
         end
         ST_WR_DIAG: begin
            op_a = cell_ff;
            op_b = diag_term;
         end
         ST_ROW_ADD: begin
            op_a = row_prefix_ff;
            op_b = cell_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      last_row_in   = last_row_ff;
      col_in        = col_ff;
      last_col_in   = last_col_ff;
      acc_in        = acc_ff;
      cell_in       = cell_ff;
      row_prefix_in = row_prefix_ff;
      diag_carry_in = diag_carry_ff;
      col_wr        = 1'b0;
      diag_wr       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = col_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               if (cmd.rows == '0 || cmd.cols == '0 || modulus < SUM_WIDTH'(2)) begin
                  cell_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  row_in        = '0;
                  col_in        = '0;
                  last_row_in   = cmd.rows - 16'd1;
                  if (int'(cmd.cols) > MAX_COLS) begin
                     last_col_in = CW'(MAX_COLS - 1);
                  end else begin
                     last_col_in = CW'(cmd.cols - 11'd1);
                  end
                  row_prefix_in = '0;
                  diag_carry_in = '0;
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  state_in      = ST_ADD_COL;
               end
            end
         end
         ST_ADD_COL: begin
            acc_in   = sum;
            state_in = ST_ADD_DIAG;
         end
         ST_ADD_DIAG: begin
            // start cell seeds the sweep
            cell_in  = (first_row && first_col) ? SUM_WIDTH'(1) : sum;
            state_in = ST_WR_COL;
         end
         ST_WR_COL: begin
            col_wr   = 1'b1;
            state_in = ST_WR_DIAG;
         end
         ST_WR_DIAG: begin
            diag_wr       = 1'b1;
            diag_carry_in = first_row ? '0 : diag_rd;
            state_in      = ST_ROW_ADD;
         end
         ST_ROW_ADD: begin
            if (col_ff == last_col_ff) begin
               if (row_ff == last_row_ff) begin
                  state_in = ST_DONE;
               end else begin
                  row_in        = row_ff + 16'd1;
                  col_in        = '0;
                  row_prefix_in = '0;
                  diag_carry_in = '0;
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  state_in      = ST_ADD_COL;
               end
            end else begin
               col_in        = col_ff + CW'(1);
               row_prefix_in = sum;
               rd_en         = 1'b1;
               rd_addr       = col_ff + CW'(1);
               state_in      = ST_ADD_COL;
            end
         end
         ST_DONE: begin
            if (ack) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         row_ff        <= '0;
         col_ff        <= '0;
         row_prefix_ff <= '0;
         diag_carry_ff <= '0;
      end else begin
         state_ff      <= state_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         row_prefix_ff <= row_prefix_in;
         diag_carry_ff <= diag_carry_in;
      end
      last_row_ff <= last_row_in;
      last_col_ff <= last_col_in;
      acc_ff      <= acc_in;
      cell_ff     <= cell_in;
   end

   assign status.idle = (state_ff == ST_IDLE);
   assign status.done = (state_ff == ST_DONE);
   assign result      = cell_ff;

endmodule

`default_nettype wire

// File: hw/rtl/queen_path_count_mod_top.sv
// top level of the queen path counter: register port, handshakes, sweep
`timescale 1ns / 1ps
`default_nettype none

// Counts the paths of queen moves (right, down, or down-right, any length) from
// the top-left to the bottom-right cell of a rows x cols grid, modulo the
// modulus register (address 0, reset 1000000007). Widths above MAX_COLS are
// clipped to MAX_COLS; zero rows, zero cols or a modulus below two give 0.
// One item is handled at a time: req_stall is high from acceptance until the
// sweep hands its result to the output register. A sweep visits one grid
// cell at a time (cols clipped to MAX_COLS), because every cell runs its five
// modular additions through a single shared adder (the column and diagonal
// stores each take one read and one write per cell). The result shows on
// rsp_valid once the finished sweep loads the output register; the next item
// can be accepted only after that hand-off, which waits on rsp_stall while the
// output register is still full. The result register lets the next item start
// while the previous result still waits on rsp_stall. The column and diagonal
// stores need no clearing: each sweep masks what it reads on its first row and
// writes every column there before a later row uses it.
module queen_path_count_mod_top #(
   parameter int MAX_COLS  = 1024,
   parameter int SUM_WIDTH = 30
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   // query items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_rows,
   input  wire logic [10:0] req_cols,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [29:0]      rsp_path_count
);

   logic [SUM_WIDTH-1:0]         modulus_ff, modulus_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [qpc_pkg::MOD_W-1:0]    rsp_count_ff, rsp_count_in;

   qpc_pkg::sweep_cmd_type       cmd;
   qpc_pkg::sweep_status_type    status;
   logic [SUM_WIDTH-1:0]         result;
   logic                         csr_write;
   logic                         load_out;

   // register port: always ready, write lands in the access phase
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      modulus_in = modulus_ff;
      if (csr_write && paddr[2] == qpc_pkg::REG_MODULUS) begin
         modulus_in = SUM_WIDTH'(pwdata[qpc_pkg::MOD_W-1:0]);
      end
   end

   always_comb begin
      if (paddr[2] == qpc_pkg::REG_MODULUS) begin
         prdata = {2'b00, qpc_pkg::MOD_W'(modulus_ff)};
      end else begin
         prdata = '0;
      end
   end

   // a new item goes straight to the sweep when it sits idle
   assign cmd.start = req_valid && status.idle;
   assign cmd.rows  = req_rows;
   assign cmd.cols  = req_cols;
   assign req_stall = !status.idle;

   qpc_sweep #(.MAX_COLS(MAX_COLS), .SUM_WIDTH(SUM_WIDTH)) u_sweep (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .modulus (modulus_ff),
      .ack     (load_out),
      .status  (status),
      .result  (result)
   );

   // result register, refilled as soon as the old item leaves
   assign load_out = status.done && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = qpc_pkg::MOD_W'(result);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= SUM_WIDTH'(qpc_pkg::MODULUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_path_count = rsp_count_ff;

`ifndef SYNTHESIS
   // an accepted item closes the input until its sweep is handed off
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input open right after an accepted item");

   // a finished sweep never coexists with an open input
   assert property (@(posedge clock) disable iff (reset)
      status.done |-> req_stall)
      else $error("input open while a result waits in the sweep");

   // a new result only appears from a finished sweep
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(status.done))
      else $error("result raised without a finished sweep");
`endif

endmodule

`default_nettype wire
